[hw/rtl/scln_pkg.sv]
package scln_pkg;

    localparam int DEFAULT_SAMPLE_BITS = 10;
    localparam int DEFAULT_OUT_MAX     = 255;

    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_DEFAULT_LOW  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_DEFAULT_HIGH = CFG_IDX_BITS'(1);

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef struct packed {
        logic load;
        logic clear;
        logic range;
        logic span;
        logic mul;
        logic div_step;
        logic out_load;
    } scln_cmd_t;

    typedef struct packed {
        logic div_last;
    } scln_stat_t;

endpackage

[hw/rtl/scln_item_if.sv]
interface scln_item_if #(
    parameter int SAMPLE_BITS = scln_pkg::DEFAULT_SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [SAMPLE_BITS-1:0] raw_sample;

    modport source (output valid, output kind, output raw_sample, input ready);
    modport sink   (input valid, input kind, input raw_sample, output ready);
endinterface

[hw/rtl/scln_result_if.sv]
interface scln_result_if #(
    parameter int LEVEL_BITS = $clog2(scln_pkg::DEFAULT_OUT_MAX + 1)
);
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] level;
    logic                  low_moved;
    logic                  high_moved;

    modport source (output valid, output level, output low_moved, output high_moved,
                    input ready);
    modport sink   (input valid, input level, input low_moved, input high_moved,
                    output ready);
endinterface

[hw/rtl/scln_cfg_if.sv]
interface scln_cfg_if #(
    parameter int SAMPLE_BITS = scln_pkg::DEFAULT_SAMPLE_BITS
);
    logic                              valid;
    logic                              ready;
    logic [scln_pkg::CFG_IDX_BITS-1:0] index;
    logic [SAMPLE_BITS-1:0]            data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/scln_ctrl.sv]
module scln_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_kind,
    output logic                 item_ready,
    output logic                 result_valid,
    input  logic                 result_ready,
    input  scln_pkg::scln_stat_t stat,
    output scln_pkg::scln_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RANGE = 3'd1;
    localparam logic [2:0] S_SPAN  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_HOLD  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item_kind == scln_pkg::KIND_CLEAR)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_RANGE;
                    end
                end
            end
            S_RANGE:
            begin
                cmd.range  = 1'b1;
                state_next = S_SPAN;
            end
            S_SPAN:
            begin
                cmd.span   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || result_ready))
        else $error("result register overwritten while pending");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && stat.div_last) |=> (state_reg == S_HOLD))
        else $error("divider did not hand over to result stage");

    a_mul_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |=> (state_reg == S_DIV))
        else $error("multiply not followed by divide");

endmodule

[hw/rtl/scln_dp.sv]
module scln_dp #(
    parameter int SAMPLE_BITS = scln_pkg::DEFAULT_SAMPLE_BITS,
    parameter int OUT_MAX     = scln_pkg::DEFAULT_OUT_MAX,
    parameter int LEVEL_BITS  = $clog2(OUT_MAX + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  scln_pkg::scln_cmd_t               cmd,
    output scln_pkg::scln_stat_t              stat,
    input  logic [SAMPLE_BITS-1:0]            item_raw_sample,
    input  logic                              cfg_we,
    input  logic [scln_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SAMPLE_BITS-1:0]            cfg_data,
    output logic [LEVEL_BITS-1:0]             level,
    output logic                              low_moved,
    output logic                              high_moved
);

    localparam int W         = SAMPLE_BITS;
    localparam int L         = LEVEL_BITS;
    localparam int PW        = W + L;
    localparam int CNT_BITS  = (L > 1) ? $clog2(L) : 1;
    localparam logic [L-1:0]        OUT_MAX_L = L'(OUT_MAX);
    localparam logic [CNT_BITS-1:0] CNT_INIT  = CNT_BITS'(L - 1);

    logic [W-1:0] dflt_low_reg,  dflt_low_next;
    logic [W-1:0] dflt_high_reg, dflt_high_next;
    logic [W-1:0] low_first_reg,  low_first_next;
    logic [W-1:0] low_second_reg, low_second_next;
    logic [W-1:0] high_first_reg,  high_first_next;
    logic [W-1:0] high_second_reg, high_second_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    logic [W-1:0] sample_reg, sample_next;
    logic [W-1:0] lo_reg, lo_next;
    logic [W-1:0] hi_reg, hi_next;
    logic         lmove_reg, lmove_next;
    logic         hmove_reg, hmove_next;
    logic [W-1:0] span_reg, span_next;
    logic [W-1:0] diff_reg, diff_next;
    logic [W:0]   rem_reg, rem_next;
    logic [L-1:0] num_reg, num_next;
    logic [L-1:0] res_level_reg, res_level_next;
    logic         res_low_moved_reg, res_low_moved_next;
    logic         res_high_moved_reg, res_high_moved_next;

    logic [W-1:0] lo_c;
    logic [W-1:0] hi_c;
    logic         lmove_c;
    logic         hmove_c;
    logic [PW-1:0] prod_c;
    logic [W:0]   trial_c;
    logic         ge_c;
    logic [L:0]   shifted_c;

    // effective range from the slots
    assign lo_c    = (low_first_reg > low_second_reg) ? low_first_reg : low_second_reg;
    assign hi_c    = (high_first_reg < high_second_reg) ? high_first_reg : high_second_reg;
    assign lmove_c = (sample_reg < lo_c);
    assign hmove_c = (sample_reg > hi_c);

    assign prod_c    = PW'(diff_reg) * PW'(OUT_MAX_L);
    assign trial_c   = {rem_reg[W-1:0], num_reg[L-1]};
    assign ge_c      = (trial_c >= {1'b0, span_reg});
    assign shifted_c = {num_reg, ge_c};

    always_comb
    begin
        dflt_low_next    = dflt_low_reg;
        dflt_high_next   = dflt_high_reg;
        low_first_next   = low_first_reg;
        low_second_next  = low_second_reg;
        high_first_next  = high_first_reg;
        high_second_next = high_second_reg;
        cnt_next         = cnt_reg;

        if (cfg_we)
        begin
            if (cfg_index == scln_pkg::REG_DEFAULT_LOW)
            begin
                dflt_low_next = cfg_data;
            end
            if (cfg_index == scln_pkg::REG_DEFAULT_HIGH)
            begin
                dflt_high_next = cfg_data;
            end
        end

        if (cmd.clear)
        begin
            low_first_next   = dflt_low_reg;
            low_second_next  = dflt_low_reg;
            high_first_next  = dflt_high_reg;
            high_second_next = dflt_high_reg;
        end

        if (cmd.range)
        begin
            if (lmove_c)
            begin
                low_first_next  = (low_first_reg < low_second_reg) ? low_first_reg
                                                                   : low_second_reg;
                low_second_next = sample_reg;
            end
            if (hmove_c)
            begin
                high_first_next  = (high_first_reg > high_second_reg) ? high_first_reg
                                                                      : high_second_reg;
                high_second_next = sample_reg;
            end
        end

        if (cmd.mul)
        begin
            cnt_next = CNT_INIT;
        end
        else if (cmd.div_step)
        begin
            cnt_next = cnt_reg - CNT_BITS'(1);
        end
    end

    always_comb
    begin
        sample_next         = sample_reg;
        lo_next             = lo_reg;
        hi_next             = hi_reg;
        lmove_next          = lmove_reg;
        hmove_next          = hmove_reg;
        span_next           = span_reg;
        diff_next           = diff_reg;
        rem_next            = rem_reg;
        num_next            = num_reg;
        res_level_next      = res_level_reg;
        res_low_moved_next  = res_low_moved_reg;
        res_high_moved_next = res_high_moved_reg;

        if (cmd.load)
        begin
            sample_next = item_raw_sample;
        end

        if (cmd.range)
        begin
            lo_next    = lo_c;
            hi_next    = hi_c;
            lmove_next = lmove_c;
            hmove_next = hmove_c;
        end

        if (cmd.span)
        begin
            if (hi_reg > lo_reg)
            begin
                span_next = hi_reg - lo_reg;
                if (sample_reg <= lo_reg)
                begin
                    diff_next = hi_reg - lo_reg;
                end
                else if (sample_reg >= hi_reg)
                begin
                    diff_next = '0;
                end
                else
                begin
                    diff_next = hi_reg - sample_reg;
                end
            end
            else
            begin
                // collapsed or inverted range
                span_next = W'(1);
                diff_next = (sample_reg <= lo_reg) ? W'(1) : '0;
            end
        end

        if (cmd.mul)
        begin
            rem_next = {1'b0, prod_c[PW-1:L]};
            num_next = prod_c[L-1:0];
        end

        if (cmd.div_step)
        begin
            rem_next = ge_c ? (trial_c - {1'b0, span_reg}) : trial_c;
            num_next = shifted_c[L-1:0];
        end

        if (cmd.out_load)
        begin
            res_level_next      = num_reg;
            res_low_moved_next  = lmove_reg;
            res_high_moved_next = hmove_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_low_reg    <= '0;
            dflt_high_reg   <= '1;
            low_first_reg   <= '0;
            low_second_reg  <= '0;
            high_first_reg  <= '1;
            high_second_reg <= '1;
            cnt_reg         <= '0;
        end
        else
        begin
            dflt_low_reg    <= dflt_low_next;
            dflt_high_reg   <= dflt_high_next;
            low_first_reg   <= low_first_next;
            low_second_reg  <= low_second_next;
            high_first_reg  <= high_first_next;
            high_second_reg <= high_second_next;
            cnt_reg         <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg         <= sample_next;
        lo_reg             <= lo_next;
        hi_reg             <= hi_next;
        lmove_reg          <= lmove_next;
        hmove_reg          <= hmove_next;
        span_reg           <= span_next;
        diff_reg           <= diff_next;
        rem_reg            <= rem_next;
        num_reg            <= num_next;
        res_level_reg      <= res_level_next;
        res_low_moved_reg  <= res_low_moved_next;
        res_high_moved_reg <= res_high_moved_next;
    end

    assign stat.div_last = (cnt_reg == '0);
    assign level         = res_level_reg;
    assign low_moved     = res_low_moved_reg;
    assign high_moved    = res_high_moved_reg;

    // partial remainder stays below the divisor
    a_rem_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |=> (rem_reg < {1'b0, span_reg}))
        else $error("initial remainder not below span");

    a_rem_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> (rem_reg < {1'b0, span_reg}))
        else $error("remainder not below span after step");

    a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.span |=> (span_reg != '0 && diff_reg <= span_reg))
        else $error("span zero or difference beyond span");

endmodule

[hw/rtl/self_calibrating_level_normalizer.sv]
// channel   role    width of payload                          moves
// item      sink    kind 1, raw_sample SAMPLE_BITS            one sample or clear per beat
// result    source  level clog2(OUT_MAX+1), low/high_moved 1  one result per sample beat
// cfg       sink    index 2, data SAMPLE_BITS                 one register write per beat
//
// a sample beat steps through load, range, span, multiply, divide and hold, with the
// restoring divider retiring one quotient bit per cycle
// a clear beat is taken in the idle state and gives no result
// the result register lets the next item in while a result waits; a new result
// waits in its last stage until the result register is free
// rst_n clears the calibration slots and the two default registers to their reset values
// cfg is always ready
module self_calibrating_level_normalizer #(
    parameter int SAMPLE_BITS = scln_pkg::DEFAULT_SAMPLE_BITS,
    parameter int OUT_MAX     = scln_pkg::DEFAULT_OUT_MAX
) (
    input  logic           clk,
    input  logic           rst_n,
    scln_item_if.sink      item,
    scln_result_if.source  result,
    scln_cfg_if.sink       cfg
);

    localparam int LEVEL_BITS = $clog2(OUT_MAX + 1);

    scln_pkg::scln_cmd_t  cmd;
    scln_pkg::scln_stat_t stat;
    logic                 cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    scln_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_kind    (item.kind),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    scln_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .OUT_MAX     (OUT_MAX),
        .LEVEL_BITS  (LEVEL_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .item_raw_sample (item.raw_sample),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .level           (result.level),
        .low_moved       (result.low_moved),
        .high_moved      (result.high_moved)
    );

endmodule

[tb/self_calibrating_level_normalizer_tb.sv]
module self_calibrating_level_normalizer_tb;

    localparam int SAMPLE_MAX = (1 << scln_pkg::DEFAULT_SAMPLE_BITS) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int IDX_BITS = scln_pkg::CFG_IDX_BITS;
    localparam logic [IDX_BITS-1:0] REG_SPARE_A = IDX_BITS'(2);
    localparam logic [IDX_BITS-1:0] REG_SPARE_B = IDX_BITS'(3);

    typedef logic [scln_pkg::DEFAULT_SAMPLE_BITS-1:0] sample_t;

    typedef struct {
        logic [7:0] level;
        logic       low_moved;
        logic       high_moved;
    } level_rec_t;

    logic clk;
    logic rst_n;

    scln_item_if   item_bus ();
    scln_result_if result_bus ();
    scln_cfg_if    cfg_bus ();

    self_calibrating_level_normalizer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // calibration state as the block should hold it
    sample_t dflt_low = '0;
    sample_t dflt_high = sample_t'(SAMPLE_MAX);
    sample_t low_a = '0;
    sample_t low_b = '0;
    sample_t high_a = sample_t'(SAMPLE_MAX);
    sample_t high_b = sample_t'(SAMPLE_MAX);

    level_rec_t level_q[$];
    int         errors = 0;
    int         cycles = 0;
    logic       steady;

    always #1 clk = ~clk;

    function automatic int eff_low();
        return (low_a > low_b) ? int'(low_a) : int'(low_b);
    endfunction

    function automatic int eff_high();
        return (high_a < high_b) ? int'(high_a) : int'(high_b);
    endfunction

    function automatic void normalize_sample(input sample_t s);
        int lo;
        int hi;
        int span;
        int x;
        level_rec_t rec;
        lo = eff_low();
        hi = eff_high();
        span = (hi > lo) ? hi - lo : 1;
        if (int'(s) <= lo)
            x = 0;
        else
            x = (int'(s) - lo < span) ? int'(s) - lo : span;
        rec.level = 8'((scln_pkg::DEFAULT_OUT_MAX * (span - x)) / span);
        rec.low_moved = int'(s) < lo;
        rec.high_moved = int'(s) > hi;
        if (rec.low_moved)
        begin
            low_a = (low_a < low_b) ? low_a : low_b;
            low_b = s;
        end
        if (rec.high_moved)
        begin
            high_a = (high_a > high_b) ? high_a : high_b;
            high_b = s;
        end
        level_q.push_back(rec);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    // beat monitor: predicts on accepted items and config writes, checks results
    always @(posedge clk)
    begin
        level_rec_t want;
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (level_q.size() == 0)
                    report_mismatch("unexpected result level", result_bus.level, -1);
                else
                begin
                    want = level_q.pop_front();
                    if (result_bus.level !== want.level)
                        report_mismatch("level", result_bus.level, want.level);
                    if (result_bus.low_moved !== want.low_moved)
                        report_mismatch("low_moved", result_bus.low_moved, want.low_moved);
                    if (result_bus.high_moved !== want.high_moved)
                        report_mismatch("high_moved", result_bus.high_moved, want.high_moved);
                end
            end
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                if (cfg_bus.index == scln_pkg::REG_DEFAULT_LOW)
                    dflt_low = cfg_bus.data;
                else if (cfg_bus.index == scln_pkg::REG_DEFAULT_HIGH)
                    dflt_high = cfg_bus.data;
            end
            if (item_bus.valid && item_bus.ready)
            begin
                if (item_bus.kind == scln_pkg::KIND_CLEAR)
                begin
                    low_a = dflt_low;
                    low_b = dflt_low;
                    high_a = dflt_high;
                    high_b = dflt_high;
                end
                else
                    normalize_sample(item_bus.raw_sample);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge clk)
        result_bus.ready = steady || ($urandom_range(99) >= 28);

    task automatic send_item(input logic kind, input sample_t s);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 28)
        begin
            item_bus.valid = 1'b0;
            @(negedge clk);
        end
        item_bus.valid = 1'b1;
        item_bus.kind = kind;
        item_bus.raw_sample = s;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
    endtask

    task automatic item_rest();
        @(negedge clk);
        item_bus.valid = 1'b0;
    endtask

    task automatic drain();
        while (level_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [IDX_BITS-1:0] index, input sample_t data);
        item_rest();
        drain();
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = index;
        cfg_bus.data = data;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    function automatic sample_t pick_sample();
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 40)
            return sample_t'($urandom);
        v = ((r < 70) ? eff_low() : eff_high()) + int'($urandom_range(16)) - 8;
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return sample_t'(v);
    endfunction

    task automatic set_defaults(input sample_t lo, input sample_t hi);
        cfg_write(scln_pkg::REG_DEFAULT_LOW, lo);
        cfg_write(scln_pkg::REG_DEFAULT_HIGH, hi);
        send_item(scln_pkg::KIND_CLEAR, sample_t'($urandom));
    endtask

    task automatic test_default_extremes();
        send_item(scln_pkg::KIND_SAMPLE, 0);
        send_item(scln_pkg::KIND_SAMPLE, sample_t'(SAMPLE_MAX));
        send_item(scln_pkg::KIND_SAMPLE, 512);
        send_item(scln_pkg::KIND_SAMPLE, 1);
        send_item(scln_pkg::KIND_SAMPLE, sample_t'(SAMPLE_MAX - 1));
        send_item(scln_pkg::KIND_SAMPLE, 10'h2aa);
        send_item(scln_pkg::KIND_SAMPLE, 10'h155);
    endtask

    task automatic test_inverted_range();
        set_defaults(700, 300);
        send_item(scln_pkg::KIND_SAMPLE, 300);
        send_item(scln_pkg::KIND_SAMPLE, 800);
        send_item(scln_pkg::KIND_SAMPLE, 500);
        // equal low and high gives span of one
        set_defaults(512, 512);
        send_item(scln_pkg::KIND_SAMPLE, 512);
        send_item(scln_pkg::KIND_SAMPLE, 513);
    endtask

    task automatic test_pair_moves();
        set_defaults(100, 900);
        send_item(scln_pkg::KIND_SAMPLE, 50);
        send_item(scln_pkg::KIND_SAMPLE, 30);
        send_item(scln_pkg::KIND_SAMPLE, 950);
        send_item(scln_pkg::KIND_SAMPLE, 990);
        send_item(scln_pkg::KIND_SAMPLE, 40);
        send_item(scln_pkg::KIND_SAMPLE, 500);
    endtask

    task automatic test_clear_and_config();
        // register write alone must not touch the slots
        cfg_write(scln_pkg::REG_DEFAULT_LOW, 400);
        send_item(scln_pkg::KIND_SAMPLE, 450);
        send_item(scln_pkg::KIND_CLEAR, sample_t'(SAMPLE_MAX));
        send_item(scln_pkg::KIND_SAMPLE, 450);
        send_item(scln_pkg::KIND_CLEAR, 0);
        send_item(scln_pkg::KIND_SAMPLE, 399);
        item_rest();
    endtask

    task automatic test_spare_index();
        cfg_write(REG_SPARE_A, 77);
        cfg_write(REG_SPARE_B, 999);
        send_item(scln_pkg::KIND_CLEAR, 0);
        send_item(scln_pkg::KIND_SAMPLE, 600);
        item_rest();
    endtask

    task automatic run_phase(input sample_t lo, input sample_t hi, input int count);
        set_defaults(lo, hi);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 4)
                send_item(scln_pkg::KIND_CLEAR, sample_t'($urandom));
            else
                send_item(scln_pkg::KIND_SAMPLE, pick_sample());
        end
        item_rest();
    endtask

    task automatic test_random_phases();
        run_phase(0, sample_t'(SAMPLE_MAX), 85);
        run_phase(sample_t'(SAMPLE_MAX), 0, 85);
        run_phase(0, 0, 85);
        run_phase(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX), 85);
        run_phase(200, 800, 85);
        for (int i = 0; i < 3; i++)
            run_phase(sample_t'($urandom), sample_t'($urandom), 85);
    endtask

    task automatic test_no_idle();
        steady = 1'b1;
        run_phase(150, 850, 100);
        drain();
        steady = 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        steady = 1'b0;
        item_bus.valid = 1'b0;
        item_bus.kind = scln_pkg::KIND_SAMPLE;
        item_bus.raw_sample = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = scln_pkg::REG_DEFAULT_LOW;
        cfg_bus.data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_extremes();
        test_inverted_range();
        test_pair_moves();
        test_clear_and_config();
        test_spare_index();
        test_random_phases();
        test_no_idle();

        item_rest();
        drain();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[self_calibrating_level_normalizer.f]
hw/rtl/scln_pkg.sv
hw/rtl/scln_item_if.sv
hw/rtl/scln_result_if.sv
hw/rtl/scln_cfg_if.sv
hw/rtl/scln_ctrl.sv
hw/rtl/scln_dp.sv
hw/rtl/self_calibrating_level_normalizer.sv
tb/self_calibrating_level_normalizer_tb.sv
